/* sv/stepper_segment_step_generator_core_macros.svh */
// Assertion macros for the step generator core.
`ifndef STEPPER_SEGMENT_STEP_GENERATOR_CORE_MACROS_SVH
`define STEPPER_SEGMENT_STEP_GENERATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SSG_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define SSG_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define SSG_ASSERT_IMP(label, clk, rst, a, c)
`define SSG_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

/* sv/ssg_pkg.sv */
package ssg_pkg;
  localparam int AXES = 8;
  localparam int DELAY_FRACTION_BITS = 5;
  localparam logic [31:0] STEP_BIT = 32'h8000_0000;

  typedef enum logic [3:0] {
    OP_FRACTION = 4'd0, OP_DIRECTION = 4'd1, OP_ACCEL_LOOPS = 4'd2,
    OP_TRAVEL_LOOPS = 4'd3, OP_DECEL_LOOPS = 4'd4, OP_INDEX = 4'd5,
    OP_ACCEL_DELAY = 4'd6, OP_TRAVEL_DELAY = 4'd7, OP_START = 4'd8,
    OP_ADVANCE = 4'd9
  } opcode_t;

  typedef enum logic [2:0] {
    PH_ACK = 3'd0, PH_ACCEL = 3'd1, PH_TRAVEL = 3'd2, PH_DECEL = 3'd3,
    PH_FINISHED = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ACCUM, ST_DIV, ST_DIV_WAIT, ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_rsp_t;
endpackage

/* sv/ssg_divider.sv */
module ssg_divider (
  input  logic              clk,
  input  logic              rst,
  input  ssg_pkg::div_req_t req,
  output ssg_pkg::div_rsp_t rsp
);
  import ssg_pkg::*;

  logic [31:0] quot, den, rem;
  logic [5:0]  count;
  logic        busy, done;
  logic [32:0] trial;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem, quot[31]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        count <= 6'd32;
        quot <= req.num;
        den <= req.den;
        rem <= '0;
      end else if (busy) begin
        if (trial[32]) begin
          rem <= {rem[30:0], quot[31]};
          quot <= {quot[30:0], 1'b0};
        end else begin
          rem <= trial[31:0];
          quot <= {quot[30:0], 1'b1};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem = rem;
endmodule

/* sv/stepper_segment_step_generator_core.sv */
// Channel  Signals                           Direction
// input    valid ready opcode axis value     in
// output   out_valid out_ready step_pulses   out
//          direction_out delay_count phase
//
// Loads, start and an advance after finish go straight to the result; any other
// advance steps through every axis, one accumulator per cycle through a shared
// adder, then, when a divide runs (accel with nonzero index, or decel), launches
// the divider and waits for it to hand back the quotient and remainder.
// Reset clears the control state, not step_pulses, delay_count or phase. ready
// is low while an item is in work and while a result waits; a stalled result holds.
`include "stepper_segment_step_generator_core_macros.svh"
module stepper_segment_step_generator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [3:0]  opcode,
  input  logic [2:0]  axis,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  step_pulses,
  output logic [7:0]  direction_out,
  output logic [31:0] delay_count,
  output logic [2:0]  phase
);
  import ssg_pkg::*;

  state_t state, state_next;
  logic [31:0] acc [AXES];
  logic [31:0] frac [AXES];
  logic [7:0]  dir;
  logic [31:0] accel_left, travel_left, decel_left, idx, adelay, tdelay, remd;
  logic        finished, is_decel;
  logic [2:0]  ax;
  logic [7:0]  pulses;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic [31:0] sum;

  ssg_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // Shared accumulator adder.
  assign sum = acc[ax] + frac[ax];
  assign ready = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign direction_out = dir;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (valid) begin
        if (opcode == OP_ADVANCE && !finished) state_next = ST_ACCUM;
        else if (opcode <= OP_ADVANCE) state_next = ST_OUT;
      end
      ST_ACCUM: if (ax == 3'(AXES - 1)) begin
        if ((accel_left != 0 && idx != 0) ||
            (accel_left == 0 && travel_left == 0 && decel_left != 0))
          state_next = ST_DIV;
        else state_next = ST_OUT;
      end
      ST_DIV: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (drsp.done) state_next = ST_OUT;
      ST_OUT: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    dreq.start = (state == ST_DIV);
    dreq.num = (adelay << 1) + remd;
    dreq.den = is_decel ? (idx << 2) - 32'd1 : (idx << 2) + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int i = 0; i < AXES; i++) begin
        acc[i] <= '0;
        frac[i] <= '0;
      end
      dir <= '0; accel_left <= '0; travel_left <= '0; decel_left <= '0;
      idx <= '0; adelay <= '0; tdelay <= '0; remd <= '0; finished <= 1'b1;
      ax <= '0; pulses <= '0; is_decel <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (valid) begin
          step_pulses <= '0;
          delay_count <= '0;
          phase <= (opcode == OP_ADVANCE && finished) ? PH_FINISHED : PH_ACK;
          ax <= '0;
          pulses <= '0;
          case (opcode)
            OP_FRACTION: if (32'(axis) < AXES) frac[axis] <= value;
            OP_DIRECTION: dir <= value[7:0];
            OP_ACCEL_LOOPS: accel_left <= value;
            OP_TRAVEL_LOOPS: travel_left <= value;
            OP_DECEL_LOOPS: decel_left <= value;
            OP_INDEX: idx <= value;
            OP_ACCEL_DELAY: adelay <= value;
            OP_TRAVEL_DELAY: tdelay <= value;
            OP_START: begin
              for (int i = 0; i < AXES; i++) acc[i] <= '0;
              remd <= '0;
              finished <= 1'b0;
            end
            OP_ADVANCE: ;
            default: ;
          endcase
        end
        ST_ACCUM: begin
          acc[ax] <= sum;
          if (!acc[ax][31] && sum[31]) pulses[ax] <= 1'b1;
          ax <= ax + 3'd1;
          if (ax == 3'(AXES - 1)) begin
            step_pulses <= pulses | (8'(!acc[ax][31] && sum[31]) << ax);
            if (accel_left != 0) begin
              is_decel <= 1'b0;
              accel_left <= accel_left - 32'd1;
              phase <= PH_ACCEL;
              delay_count <= adelay >> DELAY_FRACTION_BITS;
              if (idx == 0) idx <= 32'd1;
            end else if (travel_left != 0) begin
              travel_left <= travel_left - 32'd1;
              phase <= PH_TRAVEL;
              delay_count <= tdelay;
            end else if (decel_left != 0) begin
              is_decel <= 1'b1;
              decel_left <= decel_left - 32'd1;
              phase <= PH_DECEL;
            end else begin
              finished <= 1'b1;
              phase <= PH_FINISHED;
            end
          end
        end
        ST_DIV_WAIT: if (drsp.done) begin
          remd <= drsp.rem;
          if (is_decel) begin
            adelay <= adelay + drsp.quot;
            delay_count <= (adelay + drsp.quot) >> DELAY_FRACTION_BITS;
            idx <= idx - 32'd1;
          end else begin
            adelay <= adelay - drsp.quot;
            delay_count <= (adelay - drsp.quot) >> DELAY_FRACTION_BITS;
            idx <= idx + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  `SSG_ASSERT_IMP(a_div_only_wait, clk, rst, drsp.busy, state == ST_DIV_WAIT)
  `SSG_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(delay_count))
  `SSG_ASSERT_IMP(a_not_both, clk, rst, ready, !out_valid)
endmodule
